>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, disabled while reset is high.
`define SCA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SCA_ASSERT(lbl, clk, rst, prop, msg)
`define SCA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants, types and cell rule for the automaton step block.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int GRID_SIZE = 16;
  localparam int COLS      = GRID_SIZE / 2;
  localparam int ROW_W     = $clog2(GRID_SIZE);
  localparam int BITS_W    = 8;
  localparam int RNUM_W    = 4;
  localparam int DEPTH     = 8;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [COLS-1:0]  line_t;
  typedef logic [ROW_W-1:0] row_idx_t;

  typedef struct packed {
    logic [BITS_W-1:0] new_row_bits;
    logic [RNUM_W-1:0] row_number;
    logic              last;
  } result_t;

  // Results of one row: the previous row, then the final row on frame end.
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t res_a;
    result_t res_b;
  } push_t;

  function automatic line_t widen_row(logic [BITS_W-1:0] v);
    logic [COLS+BITS_W-1:0] t;
    t = {{COLS{1'b0}}, v};
    return t[COLS-1:0];
  endfunction

  function automatic logic [BITS_W-1:0] narrow_row(line_t v);
    logic [COLS+BITS_W-1:0] t;
    t = {{BITS_W{1'b0}}, v};
    return t[BITS_W-1:0];
  endfunction

  function automatic logic [RNUM_W-1:0] row_num(row_idx_t r);
    logic [RNUM_W+ROW_W-1:0] t;
    t = {{RNUM_W{1'b0}}, r};
    return t[RNUM_W-1:0];
  endfunction

  // One generation of the middle row; the axis column has no right neighbour.
  function automatic line_t evolve(line_t up, line_t mid, line_t dn);
    line_t      res;
    logic [COLS:0] mid_ext;
    logic [2:0] n;
    res     = mid;
    mid_ext = {1'b0, mid};
    for (int x = 1; x < COLS; x++) begin
      n = 3'(up[x]) + 3'(dn[x]) + 3'(mid_ext[x-1]) + 3'(mid_ext[x+1]);
      res[x] = mid[x] ? (n == 3'd2 || n == 3'd3) : (n <= 3'd1);
    end
    return res;
  endfunction

endpackage

>>> sv/sca_window.sv
// ----------------------------------------------------------------------------
// sca_window
// Input register, two line buffers, row counter and the cell rule.
// ----------------------------------------------------------------------------
module sca_window import sca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic [BITS_W-1:0] in_row_bits,
  input  logic              in_first_row,
  output logic              busy,
  output push_t             push
);

  logic     in_valid;
  line_t    in_row;
  logic     in_first;
  line_t    upper_line;
  line_t    middle_line;
  row_idx_t rows_seen;
  row_idx_t rows_seen_next;
  row_idx_t r;
  row_idx_t prev_row;
  logic     emit_a;
  logic     emit_b;
  line_t    bits_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_take;
    end
    if (in_take) begin
      in_row   <= widen_row(in_row_bits);
      in_first <= in_first_row;
    end
  end

  always_comb begin
    r        = in_first ? '0 : rows_seen;
    prev_row = r - 1'b1;
    emit_a   = in_valid && (r != '0);
    emit_b   = in_valid && (r == row_idx_t'(GRID_SIZE - 1));
    // row 0 is a border row and passes through
    bits_a   = (prev_row == '0) ? middle_line : evolve(upper_line, middle_line, in_row);
    rows_seen_next = emit_b ? '0 : r + 1'b1;

    push.push_a             = emit_a;
    push.push_b             = emit_b;
    push.res_a.new_row_bits = narrow_row(bits_a);
    push.res_a.row_number   = row_num(prev_row);
    push.res_a.last         = 1'b0;
    push.res_b.new_row_bits = narrow_row(in_row);
    push.res_b.row_number   = row_num(r);
    push.res_b.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_line  <= '0;
      middle_line <= '0;
      rows_seen   <= '0;
    end else if (in_valid) begin
      upper_line  <= middle_line;
      middle_line <= in_row;
      rows_seen   <= rows_seen_next;
    end
  end

  assign busy = in_valid;

endmodule

>>> sv/sca_result_fifo.sv
// ----------------------------------------------------------------------------
// sca_result_fifo
// Result queue taking up to two words per cycle and giving one while out_ready is high.
// ----------------------------------------------------------------------------
module sca_result_fifo import sca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             out_valid,
  output result_t          out_data,
  input  logic             out_ready,
  output logic [CNT_W-1:0] count
);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_b;
  logic             pop;
  logic [1:0]       n_push;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_b  = push.push_a ? wr_ptr + 1'b1 : wr_ptr;
  assign n_push    = 2'(push.push_a) + 2'(push.push_b);

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem[wr_ptr] <= push.res_a;
    end
    if (push.push_b) begin
      mem[wr_ptr_b] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

endmodule

>>> sv/sprite_cellular_automaton_step.sv
// ----------------------------------------------------------------------------
// sprite_cellular_automaton_step
// One automaton generation on a streamed half-width sprite grid.
// ----------------------------------------------------------------------------
// Takes one row per clock while s_tready is high. The first result word of
// an input word passes through the input register, the cell rule over all
// columns side by side, then the result queue. The final-row word of a frame
// is queued with it and leaves after it. Each row after the first yields the
// row before it; the final row of a frame also yields itself, so a frame of
// 16 rows gives 16 words. The eight-entry result queue sets the rate under
// back-pressure: a word is taken only while the queue has room for two
// results from it and two more from a word still in the input register.
`include "assert_macros.svh"

module sprite_cellular_automaton_step import sca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] row_bits
  input  logic        s_tuser,   // [0] first_row
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] new_row_bits, [11:8] row_number, pad
  output logic        m_tlast
);

  logic             in_take;
  logic             busy;
  push_t            push;
  result_t          res;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   committed;

  // room for the word in flight and the new one, two results each
  assign committed = {1'b0, count} + (busy ? (CNT_W+1)'(2) : '0);
  assign s_tready  = (committed <= (CNT_W+1)'(DEPTH - 2));
  assign in_take   = s_tvalid && s_tready;

  sca_window u_window (
    .clk          (clk),
    .rst          (rst),
    .in_take      (in_take),
    .in_row_bits  (s_tdata),
    .in_first_row (s_tuser),
    .busy         (busy),
    .push         (push)
  );

  sca_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (m_tvalid),
    .out_data  (res),
    .out_ready (m_tready),
    .count     (count)
  );

  assign m_tdata = {4'b0000, res.row_number, res.new_row_bits};
  assign m_tlast = res.last;

  `SCA_ASSERT(a_no_overflow, clk, rst, count <= CNT_W'(DEPTH), "result queue overflow")
  `SCA_ASSERT(a_pair_ends_frame, clk, rst, push.push_b |-> push.push_a, "final row pushed alone")
  `SCA_ASSERT(a_pop_moves_count, clk, rst, (m_tvalid && m_tready && !push.push_a) |=> count == $past(count) - 1'b1, "queue count missed a pop")
  `SCA_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule
